// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define STOK_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define STOK_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/stok_pkg.sv -----
// Shared types, codes and byte classification for the selector tokenizer.
package stok_pkg;

    localparam int MAX_TOKEN_LENGTH = 4095;
    localparam int QUEUE_DEPTH      = 4;
    localparam int LEN_W            = 12;

    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_TOKEN_LENGTH > 4095) ? 12'd4095 : LEN_W'(MAX_TOKEN_LENGTH);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_END     = 2'd1,
        KIND_EOT     = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TT_NONE   = 2'd0,
        TT_SINGLE = 2'd1,
        TT_IDENT  = 2'd2,
        TT_STRING = 2'd3
    } ttype_t;

    typedef enum logic {
        ERR_NONE         = 1'b0,
        ERR_UNTERMINATED = 1'b1
    } err_t;

    typedef struct packed {
        kind_t             kind;
        ttype_t            token_type;
        logic [7:0]        char_value;
        logic [LEN_W-1:0]  token_length;
        err_t              error_code;
    } rec_t;

    typedef struct packed {
        logic [1:0]  count;
        rec_t [2:0]  recs;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_STAR) || (c == CH_PLUS) || (c == CH_COLON) ||
               (c == CH_EQUAL) || (c == CH_GT) || (c == CH_LBRACK) ||
               (c == CH_BSLASH) || (c == CH_RBRACK);
    endfunction

    function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] v);
        return (v < LEN_CAP) ? v + LEN_W'(1) : v;
    endfunction

    function automatic rec_t make_rec(input kind_t k, input ttype_t t,
                                      input logic [7:0] ch,
                                      input logic [LEN_W-1:0] len,
                                      input err_t e);
        rec_t r;
        r.kind         = k;
        r.token_type   = t;
        r.char_value   = ch;
        r.token_length = len;
        r.error_code   = e;
        return r;
    endfunction

endpackage

// ----- hdl/stok_front.sv -----
// Front end: accepts bytes, runs the lexer state and packs each byte's results.
module stok_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_byte,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  stok_pkg::q_status_t q_status,
    output logic                push,
    output stok_pkg::bundle_t   push_data
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_STRING = 2'd2,
        MODE_ESCAPE = 2'd3
    } mode_t;

    mode_t                        mode_reg, mode_next;
    logic                         quote_single_reg, quote_single_next;
    logic [stok_pkg::LEN_W-1:0]   count_reg, count_next;
    logic                         accept;

    assign byte_stall = q_status.full;
    assign accept     = byte_valid && !q_status.full;

    always_comb
    begin
        logic [1:0]                 n;
        logic                       do_idle;
        logic [7:0]                 closer;
        logic [7:0]                 c;
        stok_pkg::bundle_t          b;

        c                 = char_byte;
        n                 = 2'd0;
        do_idle           = 1'b0;
        b                 = '0;
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        count_next        = count_reg;
        closer            = quote_single_reg ? stok_pkg::CH_SQUOTE : stok_pkg::CH_DQUOTE;

        unique case (mode_reg)
            MODE_IDENT:
            begin
                if ((c == stok_pkg::CH_NUL) || stok_pkg::is_space(c) ||
                    stok_pkg::is_quote(c) || stok_pkg::is_single(c))
                begin
                    b.recs[n] = stok_pkg::make_rec(stok_pkg::KIND_END, stok_pkg::TT_IDENT,
                                                   8'h00, count_next, stok_pkg::ERR_NONE);
                    n          = n + 2'd1;
                    count_next = '0;
                    do_idle    = 1'b1;
                end
                else
                begin
                    count_next = stok_pkg::bump(count_next);
                    b.recs[n]  = stok_pkg::make_rec(stok_pkg::KIND_CONTENT, stok_pkg::TT_IDENT,
                                                    c, '0, stok_pkg::ERR_NONE);
                    n          = n + 2'd1;
                end
            end
            MODE_STRING:
            begin
                if (c == stok_pkg::CH_NUL)
                begin
                    b.recs[n] = stok_pkg::make_rec(stok_pkg::KIND_ERROR, stok_pkg::TT_STRING,
                                                   8'h00, '0, stok_pkg::ERR_UNTERMINATED);
                    n                 = n + 2'd1;
                    mode_next         = MODE_IDLE;
                    count_next        = '0;
                    quote_single_next = 1'b0;
                end
                else if (c == closer)
                begin
                    b.recs[n] = stok_pkg::make_rec(stok_pkg::KIND_END, stok_pkg::TT_STRING,
                                                   8'h00, count_next, stok_pkg::ERR_NONE);
                    n                 = n + 2'd1;
                    mode_next         = MODE_IDLE;
                    count_next        = '0;
                    quote_single_next = 1'b0;
                end
                else if (c == stok_pkg::CH_BSLASH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    count_next = stok_pkg::bump(count_next);
                    b.recs[n]  = stok_pkg::make_rec(stok_pkg::KIND_CONTENT, stok_pkg::TT_STRING,
                                                    c, '0, stok_pkg::ERR_NONE);
                    n          = n + 2'd1;
                end
            end
            MODE_ESCAPE:
            begin
                if (c == stok_pkg::CH_NUL)
                begin
                    b.recs[n] = stok_pkg::make_rec(stok_pkg::KIND_ERROR, stok_pkg::TT_STRING,
                                                   8'h00, '0, stok_pkg::ERR_UNTERMINATED);
                    n                 = n + 2'd1;
                    mode_next         = MODE_IDLE;
                    count_next        = '0;
                    quote_single_next = 1'b0;
                end
                else if (stok_pkg::is_quote(c) || (c == stok_pkg::CH_BSLASH))
                begin
                    count_next = stok_pkg::bump(count_next);
                    b.recs[n]  = stok_pkg::make_rec(stok_pkg::KIND_CONTENT, stok_pkg::TT_STRING,
                                                    c, '0, stok_pkg::ERR_NONE);
                    n          = n + 2'd1;
                    mode_next  = MODE_STRING;
                end
                else
                begin
                    count_next = stok_pkg::bump(count_next);
                    b.recs[n]  = stok_pkg::make_rec(stok_pkg::KIND_CONTENT, stok_pkg::TT_STRING,
                                                    stok_pkg::CH_BSLASH, '0, stok_pkg::ERR_NONE);
                    n          = n + 2'd1;
                    count_next = stok_pkg::bump(count_next);
                    b.recs[n]  = stok_pkg::make_rec(stok_pkg::KIND_CONTENT, stok_pkg::TT_STRING,
                                                    c, '0, stok_pkg::ERR_NONE);
                    n          = n + 2'd1;
                    mode_next  = MODE_STRING;
                end
            end
            MODE_IDLE:
            begin
                do_idle = 1'b1;
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle)
        begin
            if (c == stok_pkg::CH_NUL)
            begin
                b.recs[n] = stok_pkg::make_rec(stok_pkg::KIND_EOT, stok_pkg::TT_NONE,
                                               8'h00, '0, stok_pkg::ERR_NONE);
                n         = n + 2'd1;
                mode_next = MODE_IDLE;
            end
            else if (stok_pkg::is_space(c))
            begin
                mode_next = MODE_IDLE;
            end
            else if (stok_pkg::is_quote(c))
            begin
                mode_next         = MODE_STRING;
                quote_single_next = (c == stok_pkg::CH_SQUOTE);
                count_next        = '0;
            end
            else if (stok_pkg::is_single(c))
            begin
                b.recs[n] = stok_pkg::make_rec(stok_pkg::KIND_CONTENT, stok_pkg::TT_SINGLE,
                                               c, '0, stok_pkg::ERR_NONE);
                n         = n + 2'd1;
                b.recs[n] = stok_pkg::make_rec(stok_pkg::KIND_END, stok_pkg::TT_SINGLE,
                                               8'h00, stok_pkg::LEN_W'(1), stok_pkg::ERR_NONE);
                n         = n + 2'd1;
                mode_next = MODE_IDLE;
            end
            else
            begin
                mode_next  = MODE_IDENT;
                count_next = stok_pkg::bump('0);
                b.recs[n]  = stok_pkg::make_rec(stok_pkg::KIND_CONTENT, stok_pkg::TT_IDENT,
                                                c, '0, stok_pkg::ERR_NONE);
                n          = n + 2'd1;
            end
        end

        b.count   = n;
        push_data = b;
        push      = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            quote_single_reg <= 1'b0;
            count_reg        <= '0;
        end
        else if (accept)
        begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            count_reg        <= count_next;
        end
    end

endmodule

// ----- hdl/stok_queue.sv -----
// Short FIFO of per-byte result bundles between front and back end.
module stok_queue #(
    parameter int DEPTH = stok_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  stok_pkg::bundle_t   push_data,
    input  logic                pop,
    output stok_pkg::bundle_t   pop_data,
    output stok_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stok_pkg::bundle_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/stok_back.sv -----
// Back end: unpacks bundles and presents one result per cycle unless result_stall holds it or no bundle is waiting.
`include "assert_macros.svh"

module stok_back (
    input  logic                clk,
    input  logic                rst_n,
    input  stok_pkg::q_status_t q_status,
    input  stok_pkg::bundle_t   pop_data,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          kind,
    output logic [1:0]          token_type,
    output logic [7:0]          char_value,
    output logic [11:0]         token_length,
    output logic                error_code,
    output logic                last_of_run
);

    stok_pkg::bundle_t bnd_reg;
    logic              valid_reg;
    logic [1:0]        idx_reg;
    stok_pkg::rec_t    rec;
    logic              last;
    logic              take;

    assign rec          = bnd_reg.recs[idx_reg];
    assign last         = (idx_reg == (bnd_reg.count - 2'd1));
    assign take         = valid_reg && !result_stall;
    assign pop          = !q_status.empty && (!valid_reg || (take && last));

    assign result_valid = valid_reg;
    assign kind         = rec.kind;
    assign token_type   = rec.token_type;
    assign char_value   = rec.char_value;
    assign token_length = rec.token_length;
    assign error_code   = rec.error_code;
    assign last_of_run  = last;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bnd_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    `STOK_ASSERT_IMPL(a_bundle_nonempty, valid_reg, bnd_reg.count != 2'd0, "empty bundle held")
    `STOK_ASSERT_IMPL(a_idx_in_range, valid_reg, idx_reg < bnd_reg.count, "result index overrun")
    `STOK_ASSERT_NEXT(a_advance, take && !last, valid_reg && (idx_reg == $past(idx_reg) + 2'd1), "result skipped")

endmodule

// ----- hdl/selector_tokenizer.sv -----
// Top level of the selector tokenizer: front end, bundle queue, back end.
//
// Usage: one expression byte per request on char_byte (byte_valid/byte_stall);
// a zero byte ends the text and returns the lexer to idle. Results leave on
// the result channel (result_valid/result_stall), one per request: content
// bytes, token ends with type and saturated length, end of text, or an
// unterminated-string error. last_of_run marks the final result of a byte.
// A byte's results pass through the bundle queue and are registered in the
// back end before they appear. The front end takes one byte per cycle while
// the queue is not full; idle whitespace and opening quotes, and a backslash
// inside a string, give no result and never touch the queue. A byte holds
// the result port until its results are taken; throughput is one result per
// cycle unless result_stall is high, set by the single back-end result port.
// The bundle queue holds QUEUE_DEPTH bytes' results. Reset: lexer idle,
// queue empty, result_valid low. When result_stall is held the queue fills
// and byte_stall rises once it is full; no byte or result is dropped.
module selector_tokenizer #(
    parameter int QUEUE_DEPTH = stok_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_byte,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [1:0]  token_type,
    output logic [7:0]  char_value,
    output logic [11:0] token_length,
    output logic        error_code,
    output logic        last_of_run
);

    stok_pkg::q_status_t q_status;
    stok_pkg::bundle_t   push_data;
    stok_pkg::bundle_t   pop_data;
    logic                push;
    logic                pop;

    stok_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_byte  (char_byte),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    stok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    stok_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .token_type   (token_type),
        .char_value   (char_value),
        .token_length (token_length),
        .error_code   (error_code),
        .last_of_run  (last_of_run)
    );

endmodule
